>>> design/bst_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bst_pkg
// shared constants, codes and types of the bounded set table
// ----------------------------------------------------------------------------
package bst_pkg;

  localparam int CapacitySlots = 32;
  localparam int ValueBits     = 32;
  localparam int IdxW          = $clog2(CapacitySlots);
  localparam int CntW          = $clog2(CapacitySlots + 1);
  localparam int ReqW          = 2;
  localparam int StatusW       = 3;

  typedef enum logic [ReqW-1:0] {
    ReqInsert = 2'd0,
    ReqErase  = 2'd1,
    ReqLookup = 2'd2,
    ReqRead   = 2'd3
  } req_e;

  typedef enum logic [StatusW-1:0] {
    StOk      = 3'd0,
    StFull    = 3'd1,
    StDup     = 3'd2,
    StMissing = 3'd3,
    StRange   = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    SIdle   = 2'd0,
    SScan   = 2'd1,
    SRdWait = 2'd2,
    SMove   = 2'd3
  } state_e;

  // one write and one read access to the entry store per cycle
  typedef struct packed {
    logic                 we;
    logic [IdxW-1:0]      waddr;
    logic [ValueBits-1:0] wdata;
    logic [IdxW-1:0]      raddr;
  } mem_req_t;

endpackage : bst_pkg

`default_nettype wire

>>> design/bst_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bst_ram
// entry store: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module bst_ram (
  input  wire logic                        clk_i,
  input  wire bst_pkg::mem_req_t           req_i,
  output logic [bst_pkg::ValueBits-1:0]    rdata_o
);

  logic [bst_pkg::ValueBits-1:0] mem_q [bst_pkg::CapacitySlots];
  logic [bst_pkg::ValueBits-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem_q[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule : bst_ram

`default_nettype wire

>>> design/bst_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bst_ctrl
// request sequencer: slot scan, insert, erase with move of the last entry,
// slot read, and the registered result
// ----------------------------------------------------------------------------
module bst_ctrl (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [bst_pkg::ReqW-1:0]          req_type_i,
  input  wire logic [bst_pkg::ValueBits-1:0]     value_i,
  input  wire logic [bst_pkg::IdxW-1:0]          slot_i,
  output bst_pkg::mem_req_t                      mem_req_o,
  input  wire logic [bst_pkg::ValueBits-1:0]     mem_rdata_i,
  output logic                                   done_o,
  output logic [bst_pkg::StatusW-1:0]            status_o,
  output logic                                   found_o,
  output logic [bst_pkg::IdxW-1:0]               found_slot_o,
  output logic [bst_pkg::ValueBits-1:0]          read_value_o,
  output logic [bst_pkg::CntW-1:0]               entry_count_o
);

  bst_pkg::state_e  state_q, state_d;
  bst_pkg::req_e    req_q, req_d;
  logic [bst_pkg::ValueBits-1:0] value_q, value_d;
  logic [bst_pkg::IdxW-1:0]      idx_q, idx_d;
  logic [bst_pkg::IdxW-1:0]      where_q, where_d;
  logic [bst_pkg::CntW-1:0]      count_q, count_d;

  logic                          done_q, done_d;
  bst_pkg::status_e              status_q, status_d;
  logic                          found_q, found_d;
  logic [bst_pkg::IdxW-1:0]      fslot_q, fslot_d;
  logic [bst_pkg::ValueBits-1:0] rval_q, rval_d;

  bst_pkg::req_e                 req_in;
  logic                          accept;
  logic                          match;
  logic                          last_slot;
  logic                          slot_ok;
  logic                          is_empty;
  logic                          is_full;
  logic [bst_pkg::IdxW-1:0]      idx_next;

  assign req_in    = bst_pkg::req_e'(req_type_i);
  assign accept    = start && (state_q == bst_pkg::SIdle);
  assign match     = (mem_rdata_i == value_q);
  assign idx_next  = bst_pkg::IdxW'(idx_q + bst_pkg::IdxW'(1));
  assign last_slot = (bst_pkg::CntW'({1'b0, idx_q}) + bst_pkg::CntW'(1)) >= count_q;
  assign slot_ok   = bst_pkg::CntW'({1'b0, slot_i}) < count_q;
  assign is_empty  = (count_q == '0);
  assign is_full   = (count_q == bst_pkg::CntW'(bst_pkg::CapacitySlots));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bst_pkg::SIdle: begin
        if (accept) begin
          if (req_in == bst_pkg::ReqRead) begin
            state_d = slot_ok ? bst_pkg::SRdWait : bst_pkg::SIdle;
          end else begin
            state_d = is_empty ? bst_pkg::SIdle : bst_pkg::SScan;
          end
        end
      end
      bst_pkg::SScan: begin
        if (match) begin
          state_d = (req_q == bst_pkg::ReqErase) ? bst_pkg::SMove : bst_pkg::SIdle;
        end else if (last_slot) begin
          state_d = bst_pkg::SIdle;
        end
      end
      bst_pkg::SRdWait: state_d = bst_pkg::SIdle;
      bst_pkg::SMove:   state_d = bst_pkg::SIdle;
      default:          state_d = bst_pkg::SIdle;
    endcase
  end

  // datapath, memory access and result
  always_comb begin
    req_d     = req_q;
    value_d   = value_q;
    idx_d     = idx_q;
    where_d   = where_q;
    count_d   = count_q;
    done_d    = 1'b0;
    status_d  = status_q;
    found_d   = found_q;
    fslot_d   = fslot_q;
    rval_d    = rval_q;
    mem_req_o.we    = 1'b0;
    mem_req_o.waddr = count_q[bst_pkg::IdxW-1:0];
    mem_req_o.wdata = value_q;
    mem_req_o.raddr = idx_next;

    unique case (state_q)
      bst_pkg::SIdle: begin
        if (accept) begin
          req_d   = req_in;
          value_d = value_i;
          idx_d   = '0;
          status_d = bst_pkg::StOk;
          found_d  = 1'b0;
          fslot_d  = '0;
          rval_d   = '0;
          if (req_in == bst_pkg::ReqRead) begin
            mem_req_o.raddr = slot_i;
            if (!slot_ok) begin
              done_d   = 1'b1;
              status_d = bst_pkg::StRange;
            end
          end else begin
            mem_req_o.raddr = '0;
            if (is_empty) begin
              done_d = 1'b1;
              if (req_in == bst_pkg::ReqInsert) begin
                // empty table: first entry goes straight in
                mem_req_o.we    = 1'b1;
                mem_req_o.waddr = '0;
                mem_req_o.wdata = value_i;
                count_d         = bst_pkg::CntW'(1);
              end else begin
                status_d = bst_pkg::StMissing;
              end
            end
          end
        end
      end
      bst_pkg::SScan: begin
        idx_d = idx_next;
        if (match) begin
          where_d = idx_q;
          found_d = 1'b1;
          fslot_d = idx_q;
          case (req_q)
            bst_pkg::ReqInsert: begin
              done_d   = 1'b1;
              status_d = bst_pkg::StDup;
            end
            bst_pkg::ReqErase: begin
              // fetch the last entry to fill the hole
              mem_req_o.raddr = bst_pkg::IdxW'(count_q - bst_pkg::CntW'(1));
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end else if (last_slot) begin
          done_d = 1'b1;
          if (req_q == bst_pkg::ReqInsert) begin
            if (is_full) begin
              status_d = bst_pkg::StFull;
            end else begin
              mem_req_o.we = 1'b1;
              count_d      = bst_pkg::CntW'(count_q + bst_pkg::CntW'(1));
            end
          end else begin
            status_d = bst_pkg::StMissing;
          end
        end
      end
      bst_pkg::SMove: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = where_q;
        mem_req_o.wdata = mem_rdata_i;
        count_d         = bst_pkg::CntW'(count_q - bst_pkg::CntW'(1));
        done_d          = 1'b1;
      end
      bst_pkg::SRdWait: begin
        rval_d = mem_rdata_i;
        done_d = 1'b1;
      end
      default: begin
        done_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bst_pkg::SIdle;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    value_q  <= value_d;
    idx_q    <= idx_d;
    where_q  <= where_d;
    status_q <= status_d;
    found_q  <= found_d;
    fslot_q  <= fslot_d;
    rval_q   <= rval_d;
  end

  assign busy          = (state_q != bst_pkg::SIdle);
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign found_o       = found_q;
  assign found_slot_o  = fslot_q;
  assign read_value_o  = rval_q;
  assign entry_count_o = count_q;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= bst_pkg::CntW'(bst_pkg::CapacitySlots))
    else $error("entry count above capacity");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> state_q == bst_pkg::SIdle)
    else $error("result shown while a request is still in work");

  a_count_moves_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> done_q)
    else $error("entry count changed without a result");

  // a move stays inside the packed region, an append lands just past it
  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req_o.we |-> (bst_pkg::CntW'({1'b0, mem_req_o.waddr}) < count_q) ||
                     ((bst_pkg::CntW'({1'b0, mem_req_o.waddr}) == count_q) && !is_full))
    else $error("write outside the packed region");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bst_pkg::SScan) |-> (bst_pkg::CntW'({1'b0, idx_q}) < count_q))
    else $error("scan beyond the last entry");
`endif

endmodule : bst_ctrl

`default_nettype wire

>>> design/bounded_set_table_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_set_table_top
// bounded table of distinct values with insert, erase, lookup and slot read
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low, and gives exactly
// one result, shown for a single cycle with done_o high; the receiver cannot
// hold it off, so it must capture it in that cycle. Insert, erase and lookup
// compare one stored entry per cycle against the value, from slot 0 up to
// the first match or the last entry, through the single read port of the
// entry memory. Busy is high while entries are compared (none on an empty
// table, up to 32), while an erase that hits moves the last entry into the
// freed slot, and while a slot read waits for its data; a slot read that
// misses the packed region does not raise busy. The result is shown in the
// first cycle in which busy is low again (the cycle right after the accept
// when busy never rises), and a new request may be taken at the edge that
// ends that cycle.
// No clearing pass after reset: only data from slots below the count is ever used.
// ----------------------------------------------------------------------------
module bounded_set_table_top (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // request side
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [bst_pkg::ReqW-1:0]          req_type_i,
  input  wire logic [bst_pkg::ValueBits-1:0]     value_i,
  input  wire logic [bst_pkg::IdxW-1:0]          slot_i,
  // result side
  output logic                                   done_o,
  output logic [bst_pkg::StatusW-1:0]            status_o,
  output logic                                   found_o,
  output logic [bst_pkg::IdxW-1:0]               found_slot_o,
  output logic [bst_pkg::ValueBits-1:0]          read_value_o,
  output logic [bst_pkg::CntW-1:0]               entry_count_o
);

  // access to the entry store and its registered read data
  bst_pkg::mem_req_t             mem_req;
  logic [bst_pkg::ValueBits-1:0] mem_rdata;

  // sequencer: owns the count, the scan index and the result registers;
  // a read may hit the entry written in the same cycle only when that read
  // data is thrown away, since every write ends a request and the reads of
  // the next request start with its accept
  bst_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .req_type_i    (req_type_i),
    .value_i       (value_i),
    .slot_i        (slot_i),
    .mem_req_o     (mem_req),
    .mem_rdata_i   (mem_rdata),
    .done_o        (done_o),
    .status_o      (status_o),
    .found_o       (found_o),
    .found_slot_o  (found_slot_o),
    .read_value_o  (read_value_o),
    .entry_count_o (entry_count_o)
  );

  // entry store, packed in slots 0 to count-1
  bst_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

endmodule : bounded_set_table_top

`default_nettype wire
